// ===== hdl/lctc_pkg.sv =====
// ----------------------------------------------------------------------------
// lctc_pkg
// Shared types, constants and helpers for the load-cell tare calibrator.
// ----------------------------------------------------------------------------
package lctc_pkg;

    localparam int unsigned MaxCalSamples = 4096;
    localparam int unsigned SigmaMultiple = 3;
    localparam int unsigned IdxW          = 13;

    localparam logic [1:0] CfgFactor  = 2'd0;
    localparam logic [1:0] CfgFloor   = 2'd1;
    localparam logic [1:0] CfgSamples = 2'd2;

    localparam logic signed [31:0] RstFactor  = 32'sd65536;
    localparam logic [31:0]        RstFloor   = 32'd300648;
    localparam logic [IdxW-1:0]    RstSamples = IdxW'(1000);

    typedef enum logic [1:0] {
        OP_DIV,
        OP_SQRT
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_READ,
        S_DIV,
        S_RES,
        S_MUL2,
        S_ACC,
        S_CHK,
        S_DIV2,
        S_SQRT,
        S_OUT
    } t_state;

    function automatic logic signed [31:0] f_sat32(input logic signed [63:0] v);
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            return -32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

// ===== hdl/load_cell_tare_calibrator_core.sv =====
// ----------------------------------------------------------------------------
// load_cell_tare_calibrator_core
// Scales bridge voltage to weight, removes tare offset plus three sigma, and
// runs a Welford mean / M2 calibration with a shared divide / sqrt unit.
// ----------------------------------------------------------------------------
//  channel | signals                                   | handshake
//  in      | i_kind, i_fresh, i_voltage                | i_in_valid / o_in_stall
//  out     | o_weight, o_calibrating, o_calibration_done,| o_out_valid / i_out_stall
//          | o_offset_out, o_deviation_out             |
//  cfg     | i_cfg_index, i_cfg_data                   | i_cfg_valid / o_cfg_ready
//
//  Plain sample or start beat: multiply, read, output. Sample inside a run:
//  adds a divider pass for the mean update and the M2 accumulate. Final
//  sample of a run: adds an M2 divide and a square root as well.
//  Synchronous active-low reset; config reset values apply at once.
//  o_in_stall is high while a beat is in work; a held output beat does not
//  block the next input until the result register is needed again.
// ----------------------------------------------------------------------------
module load_cell_tare_calibrator_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_kind,
    input  logic                i_fresh,
    input  logic signed [31:0]  i_voltage,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [31:0]  o_weight,
    output logic                o_calibrating,
    output logic                o_calibration_done,
    output logic signed [31:0]  o_offset_out,
    output logic [30:0]         o_deviation_out,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    import lctc_pkg::*;

    t_state r_state, n_state;

    logic signed [31:0] r_factor;
    logic [31:0]        r_floor;
    logic [IdxW-1:0]    r_samples;

    logic               r_kind;
    logic signed [31:0] r_held;
    logic signed [63:0] r_prod;
    logic signed [31:0] r_reading;
    logic signed [31:0] r_weight;
    logic signed [31:0] r_offset;
    logic [30:0]        r_dev;
    logic signed [31:0] r_mean;
    logic [63:0]        r_m2;
    logic [IdxW-1:0]    r_idx;
    logic               r_coll;
    logic               r_done_flag;
    logic signed [31:0] r_delta;
    logic signed [31:0] r_resid;
    logic [63:0]        r_mprod;
    logic               r_add;

    logic               r_out_valid;
    logic signed [31:0] r_o_weight;
    logic               r_o_cal;
    logic               r_o_done;
    logic signed [31:0] r_o_offset;
    logic [30:0]        r_o_dev;

    logic               u_start;
    t_op                u_op;
    logic [63:0]        u_num;
    logic [31:0]        u_den;
    logic               u_done;
    logic [63:0]        u_res;

    logic               in_acc;
    logic               out_free;
    logic [IdxW-1:0]    target;
    logic [IdxW-1:0]    idx_next;
    logic signed [31:0] reading_c;
    logic signed [31:0] delta_c;
    logic [31:0]        dmag;
    logic [31:0]        rmag;
    logic signed [33:0] q_s;
    logic [64:0]        m2_sum;
    logic [31:0]        sd;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign idx_next = r_idx + IdxW'(1);

    always_comb begin
        if (r_samples < IdxW'(2)) begin
            target = IdxW'(2);
        end else if (r_samples > IdxW'(MaxCalSamples)) begin
            target = IdxW'(MaxCalSamples);
        end else begin
            target = r_samples;
        end
    end

    assign reading_c = f_sat32(r_prod >>> 16);
    assign delta_c   = f_sat32(64'(reading_c) - 64'(r_mean));
    assign dmag      = r_delta[31] ? 32'(-r_delta) : 32'(r_delta);
    assign rmag      = r_resid[31] ? 32'(-r_resid) : 32'(r_resid);
    assign q_s       = r_delta[31] ? -$signed({2'b00, u_res[31:0]})
                                   : $signed({2'b00, u_res[31:0]});
    assign m2_sum    = {1'b0, r_m2} + {1'b0, r_mprod};
    assign sd        = u_res[31:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (in_acc) n_state = S_MUL;
            S_MUL:  n_state = S_READ;
            S_READ: begin
                if (!r_kind && r_coll) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_DIV:  if (u_done) n_state = S_RES;
            S_RES:  n_state = S_MUL2;
            S_MUL2: n_state = S_ACC;
            S_ACC:  n_state = S_CHK;
            S_CHK:  n_state = (r_idx >= target) ? S_DIV2 : S_OUT;
            S_DIV2: if (u_done) n_state = S_SQRT;
            S_SQRT: if (u_done) n_state = S_OUT;
            S_OUT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // unit control
    always_comb begin
        u_start = 1'b0;
        u_op    = OP_DIV;
        u_num   = '0;
        u_den   = '0;
        case (r_state)
            S_READ: begin
                u_start = !r_kind && r_coll;
                u_num   = {32'd0, (delta_c[31] ? 32'(-delta_c) : 32'(delta_c))};
                u_den   = 32'(idx_next);
            end
            S_CHK: begin
                u_start = (r_idx >= target);
                u_num   = r_m2;
                u_den   = 32'(r_idx - IdxW'(1));
            end
            S_DIV2: begin
                u_start = u_done;
                u_op    = OP_SQRT;
                u_num   = (u_res < {32'd0, r_floor}) ? {32'd0, r_floor} : u_res;
            end
            default: begin
                u_start = 1'b0;
            end
        endcase
    end

    lctc_iter u_iter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (u_start),
        .i_op     (u_op),
        .i_num    (u_num),
        .i_den    (u_den),
        .o_done   (u_done),
        .o_result (u_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_factor    <= RstFactor;
            r_floor     <= RstFloor;
            r_samples   <= RstSamples;
            r_held      <= '0;
            r_offset    <= '0;
            r_dev       <= '0;
            r_mean      <= '0;
            r_m2        <= '0;
            r_idx       <= '0;
            r_coll      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CfgFactor:  r_factor  <= i_cfg_data;
                    CfgFloor:   r_floor   <= i_cfg_data;
                    CfgSamples: r_samples <= i_cfg_data[IdxW-1:0];
                    default:    r_samples <= r_samples;
                endcase
            end
            if (r_out_valid && !i_out_stall && !(r_state == S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_kind      <= i_kind;
                        r_done_flag <= 1'b0;
                        if (!i_kind && i_fresh) begin
                            r_held <= i_voltage;
                        end
                    end
                end
                S_MUL: begin
                    r_prod <= 64'(r_held) * 64'(r_factor);
                end
                S_READ: begin
                    r_reading <= reading_c;
                    r_weight  <= f_sat32(64'(reading_c) - 64'(r_offset)
                                 - 64'(SigmaMultiple) * 64'({1'b0, r_dev}));
                    if (r_kind) begin
                        r_coll <= 1'b1;
                        r_idx  <= '0;
                        r_mean <= '0;
                        r_m2   <= '0;
                    end else if (r_coll) begin
                        r_idx   <= idx_next;
                        r_delta <= delta_c;
                    end
                end
                S_DIV: begin
                    if (u_done) begin
                        r_mean <= f_sat32(64'(r_mean) + 64'(q_s));
                    end
                end
                S_RES: begin
                    r_resid <= f_sat32(64'(r_reading) - 64'(r_mean));
                end
                S_MUL2: begin
                    r_mprod <= 64'(dmag) * 64'(rmag);
                    r_add   <= (r_delta[31] == r_resid[31]);
                end
                S_ACC: begin
                    if (r_add) begin
                        r_m2 <= m2_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : m2_sum[63:0];
                    end
                end
                S_SQRT: begin
                    if (u_done) begin
                        r_dev       <= sd[31] ? 31'h7FFF_FFFF : sd[30:0];
                        r_offset    <= r_mean;
                        r_coll      <= 1'b0;
                        r_idx       <= '0;
                        r_done_flag <= 1'b1;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_weight  <= r_weight;
                        r_o_cal     <= r_coll;
                        r_o_done    <= r_done_flag;
                        r_o_offset  <= r_offset;
                        r_o_dev     <= r_dev;
                    end
                end
                default: begin
                    r_kind <= r_kind;
                end
            endcase
        end
    end

    assign o_in_stall         = (r_state != S_IDLE);
    assign o_cfg_ready        = 1'b1;
    assign o_out_valid        = r_out_valid;
    assign o_weight           = r_o_weight;
    assign o_calibrating      = r_o_cal;
    assign o_calibration_done = r_o_done;
    assign o_offset_out       = r_o_offset;
    assign o_deviation_out    = r_o_dev;

endmodule

// ===== hdl/lctc_iter.sv =====
// ----------------------------------------------------------------------------
// lctc_iter
// Shared restoring divider (64/32, one bit a cycle) and integer square root
// (64-bit radicand, two bits a cycle) on one compare-subtract unit.
// ----------------------------------------------------------------------------
module lctc_iter (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  lctc_pkg::t_op    i_op,
    input  logic [63:0]      i_num,
    input  logic [31:0]      i_den,
    output logic             o_done,
    output logic [63:0]      o_result
);
    import lctc_pkg::*;

    logic        r_busy;
    logic        r_done;
    t_op         r_op;
    logic [6:0]  r_cnt;
    logic [35:0] r_rem;
    logic [63:0] r_num;
    logic [31:0] r_root;
    logic [31:0] r_den;

    logic [35:0] partial;
    logic [35:0] trial;
    logic [35:0] diff;
    logic        ge;

    always_comb begin
        if (r_op == OP_SQRT) begin
            partial = {r_rem[33:0], r_num[63:62]};
            trial   = {2'b00, r_root, 2'b01};
        end else begin
            partial = {r_rem[34:0], r_num[63]};
            trial   = {4'b0000, r_den};
        end
        ge   = (partial >= trial);
        diff = partial - trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= OP_DIV;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_op   <= i_op;
                r_cnt  <= (i_op == OP_SQRT) ? 7'd32 : 7'd64;
                r_rem  <= '0;
                r_num  <= i_num;
                r_root <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= ge ? diff : partial;
                if (r_op == OP_SQRT) begin
                    r_num  <= {r_num[61:0], 2'b00};
                    r_root <= {r_root[30:0], ge};
                end else begin
                    r_num <= {r_num[62:0], ge};
                end
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = (r_op == OP_SQRT) ? {32'd0, r_root} : r_num;

endmodule
